// File: design/ow_pkg.sv
// Shared types, codes and reset constants for the one-wire bus master.
// Used by every design module and the checker.
package ow_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned TIMER_W = 10;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [6:0] IDLE_WAIT_RST = 7'd100;
	localparam logic [9:0] RESET_LOW_RST = 10'd480;
	localparam logic [7:0] PRES_SAMPLE_RST = 8'd80;
	localparam logic [7:0] RELEASE_WAIT_RST = 8'd240;
	localparam logic [6:0] ZERO_LOW_RST = 7'd65;
	localparam logic [6:0] ONE_RELEASE_RST = 7'd65;
	localparam logic [5:0] READ_SAMPLE_RST = 6'd14;
	localparam logic [6:0] READ_TAIL_RST = 7'd50;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_IDLE = 2'd1;
	localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
	localparam logic [1:0] ST_NOT_GONE = 2'd3;

	typedef enum logic [2:0] {
		REG_IDLE_WAIT = 3'd0,
		REG_RESET_LOW = 3'd1,
		REG_PRES_SAMPLE = 3'd2,
		REG_RELEASE_WAIT = 3'd3,
		REG_ZERO_LOW = 3'd4,
		REG_ONE_RELEASE = 3'd5,
		REG_READ_SAMPLE = 3'd6,
		REG_READ_TAIL = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_RST_IDLE = 4'd1,
		PH_RST_LOW = 4'd2,
		PH_RST_PRES = 4'd3,
		PH_RST_GONE = 4'd4,
		PH_WR_LOW = 4'd5,
		PH_WR_REC = 4'd6,
		PH_RD_LOW = 4'd7,
		PH_RD_WAIT = 4'd8,
		PH_RD_TAIL = 4'd9
	} phase_t;

	typedef struct packed {
		logic tick;
		logic line_high;
		logic [1:0] command;
		logic [7:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic drive_low;
		logic busy_res;
		logic done_res;
		logic [1:0] status;
		logic [7:0] read_data;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_item_t;

	typedef struct packed {
		logic tick;
		logic line_high;
		op_t op;
		logic [7:0] write_data;
	} q_item_t;

	typedef struct packed {
		logic [6:0] idle_wait_limit;
		logic [9:0] reset_low_time;
		logic [7:0] presence_sample_time;
		logic [7:0] release_wait_limit;
		logic [6:0] zero_low_time;
		logic [6:0] one_release_time;
		logic [5:0] read_sample_time;
		logic [6:0] read_tail_time;
	} cfg_regs_t;

endpackage

// File: design/ow_chan_if.sv
// Valid/ready channel interface carrying one payload item per handshake.
// The payload type is a parameter; the types come from ow_pkg.
interface ow_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input ready, input data);
endinterface

// File: design/onewire_bus_master.sv
// One-wire bus master: one result item per input item, passed through the
// queue and then the output register. Throughput is one item per cycle
// while out_ch is ready, set by the single-step sequencer and the queue
// between front and back, which absorbs a stall of the output side.
// Reset clears the queue, the sequencer to idle and the timing registers to
// their defaults; the block takes items from the first cycle after reset.
module onewire_bus_master #(
	parameter int unsigned QueueDepth = ow_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	ow_chan_if.sink in_ch,
	ow_chan_if.source out_ch,
	ow_chan_if.sink cfg_ch
);
	ow_pkg::cfg_regs_t regs;
	ow_pkg::q_item_t q_item;
	logic q_valid;
	logic pop;

	ow_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_ch(cfg_ch),
		.regs(regs)
	);

	ow_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.pop(pop),
		.q_valid(q_valid),
		.q_item(q_item)
	);

	ow_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.regs(regs),
		.q_valid(q_valid),
		.q_item(q_item),
		.pop(pop),
		.out_ch(out_ch)
	);
endmodule

// File: design/ow_cfg.sv
// Timing register file of the one-wire bus master, written over the
// configuration channel. Depends on ow_pkg and ow_chan_if.
module ow_cfg (
	input logic clk,
	input logic arst_n,
	ow_chan_if.sink cfg_ch,
	output ow_pkg::cfg_regs_t regs
);
	ow_pkg::cfg_regs_t regs_q;
	logic wr_en;

	assign cfg_ch.ready = 1'b1;
	assign wr_en = cfg_ch.valid;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.idle_wait_limit <= ow_pkg::IDLE_WAIT_RST;
			regs_q.reset_low_time <= ow_pkg::RESET_LOW_RST;
			regs_q.presence_sample_time <= ow_pkg::PRES_SAMPLE_RST;
			regs_q.release_wait_limit <= ow_pkg::RELEASE_WAIT_RST;
			regs_q.zero_low_time <= ow_pkg::ZERO_LOW_RST;
			regs_q.one_release_time <= ow_pkg::ONE_RELEASE_RST;
			regs_q.read_sample_time <= ow_pkg::READ_SAMPLE_RST;
			regs_q.read_tail_time <= ow_pkg::READ_TAIL_RST;
		end else if (wr_en) begin
			case (ow_pkg::reg_idx_t'(cfg_ch.data.index))
				ow_pkg::REG_IDLE_WAIT: regs_q.idle_wait_limit <= cfg_ch.data.value[6:0];
				ow_pkg::REG_RESET_LOW: regs_q.reset_low_time <= cfg_ch.data.value[9:0];
				ow_pkg::REG_PRES_SAMPLE: regs_q.presence_sample_time <= cfg_ch.data.value[7:0];
				ow_pkg::REG_RELEASE_WAIT: regs_q.release_wait_limit <= cfg_ch.data.value[7:0];
				ow_pkg::REG_ZERO_LOW: regs_q.zero_low_time <= cfg_ch.data.value[6:0];
				ow_pkg::REG_ONE_RELEASE: regs_q.one_release_time <= cfg_ch.data.value[6:0];
				ow_pkg::REG_READ_SAMPLE: regs_q.read_sample_time <= cfg_ch.data.value[5:0];
				ow_pkg::REG_READ_TAIL: regs_q.read_tail_time <= cfg_ch.data.value[6:0];
				default: begin
				end
			endcase
		end
	end
endmodule

// File: design/ow_front.sv
// Front end: accepts input items, decodes the command code and holds the
// items in a short queue for the sequencer. Depends on ow_pkg and ow_chan_if.
module ow_front #(
	parameter int unsigned QueueDepth = ow_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	ow_chan_if.sink in_ch,
	input logic pop,
	output logic q_valid,
	output ow_pkg::q_item_t q_item
);
	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	ow_pkg::q_item_t entry_q [QueueDepth];
	ow_pkg::q_item_t push_item;
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push;
	logic do_pop;

	assign in_ch.ready = (count_q != CntW'(QueueDepth));
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (count_q != '0);
	assign do_pop = pop && q_valid;
	assign q_item = entry_q[rd_ptr_q];

	always_comb begin
		push_item.tick = in_ch.data.tick;
		push_item.line_high = in_ch.data.line_high;
		push_item.write_data = in_ch.data.write_data;
		case (in_ch.data.command)
			ow_pkg::CMD_RESET: push_item.op = ow_pkg::OP_RESET;
			ow_pkg::CMD_WRITE: push_item.op = ow_pkg::OP_WRITE;
			ow_pkg::CMD_READ: push_item.op = ow_pkg::OP_READ;
			default: push_item.op = ow_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// File: design/ow_back.sv
// Back end: the bus sequencer that runs reset, write and read slots, and the
// output register that holds one result item. Depends on ow_pkg and ow_chan_if.
module ow_back (
	input logic clk,
	input logic arst_n,
	input ow_pkg::cfg_regs_t regs,
	input logic q_valid,
	input ow_pkg::q_item_t q_item,
	output logic pop,
	ow_chan_if.source out_ch
);
	ow_pkg::phase_t phase_q;
	ow_pkg::phase_t phase_d;
	logic [ow_pkg::TIMER_W-1:0] timer_q;
	logic [ow_pkg::TIMER_W-1:0] timer_d;
	logic [ow_pkg::TIMER_W-1:0] timer_inc;
	logic [ow_pkg::TIMER_W-1:0] limit;
	logic [7:0] shift_q;
	logic [7:0] shift_d;
	logic [2:0] count_q;
	logic [2:0] count_d;
	logic [1:0] status_q;
	logic [1:0] status_d;
	logic [7:0] rbyte_q;
	logic [7:0] rbyte_d;
	logic done;
	logic hit;
	logic cur_bit;
	logic fire;
	logic out_valid_q;
	ow_pkg::out_item_t out_q;
	ow_pkg::out_item_t out_d;

	assign fire = q_valid && (!out_valid_q || out_ch.ready);
	assign pop = fire;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
	assign cur_bit = shift_q[0];
	assign timer_inc = timer_q + 1'b1;
	assign hit = (timer_inc >= limit);

	always_comb begin
		case (phase_q)
			ow_pkg::PH_RST_IDLE: limit = ow_pkg::TIMER_W'(regs.idle_wait_limit);
			ow_pkg::PH_RST_LOW: limit = regs.reset_low_time;
			ow_pkg::PH_RST_PRES: limit = ow_pkg::TIMER_W'(regs.presence_sample_time);
			ow_pkg::PH_RST_GONE: limit = ow_pkg::TIMER_W'(regs.release_wait_limit);
			ow_pkg::PH_WR_LOW: limit = cur_bit ? ow_pkg::TIMER_W'(1) :
				ow_pkg::TIMER_W'(regs.zero_low_time);
			ow_pkg::PH_WR_REC: limit = cur_bit ? ow_pkg::TIMER_W'(regs.one_release_time) :
				ow_pkg::TIMER_W'(1);
			ow_pkg::PH_RD_WAIT: limit = ow_pkg::TIMER_W'(regs.read_sample_time);
			ow_pkg::PH_RD_TAIL: limit = ow_pkg::TIMER_W'(regs.read_tail_time);
			default: limit = ow_pkg::TIMER_W'(1);
		endcase
	end

	// Next state of the sequencer for the item at the head of the queue.
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		shift_d = shift_q;
		count_d = count_q;
		status_d = status_q;
		rbyte_d = rbyte_q;
		done = 1'b0;
		if (phase_q == ow_pkg::PH_IDLE) begin
			count_d = 3'd0;
			case (q_item.op)
				ow_pkg::OP_RESET: begin
					phase_d = ow_pkg::PH_RST_IDLE;
					timer_d = '0;
				end
				ow_pkg::OP_WRITE: begin
					shift_d = q_item.write_data;
					phase_d = ow_pkg::PH_WR_LOW;
					timer_d = '0;
				end
				ow_pkg::OP_READ: begin
					shift_d = 8'd0;
					phase_d = ow_pkg::PH_RD_LOW;
					timer_d = '0;
				end
				default: count_d = count_q;
			endcase
		end else if (q_item.tick) begin
			timer_d = hit ? '0 : timer_inc;
			case (phase_q)
				ow_pkg::PH_RST_IDLE: begin
					if (q_item.line_high) begin
						phase_d = ow_pkg::PH_RST_LOW;
						timer_d = '0;
					end else if (hit) begin
						status_d = ow_pkg::ST_NOT_IDLE;
						done = 1'b1;
					end
				end
				ow_pkg::PH_RST_LOW: begin
					if (hit) begin
						phase_d = ow_pkg::PH_RST_PRES;
					end
				end
				ow_pkg::PH_RST_PRES: begin
					if (hit) begin
						if (q_item.line_high) begin
							status_d = ow_pkg::ST_NOT_PRESENT;
							done = 1'b1;
						end else begin
							phase_d = ow_pkg::PH_RST_GONE;
						end
					end
				end
				ow_pkg::PH_RST_GONE: begin
					if (q_item.line_high) begin
						timer_d = timer_q;
						status_d = ow_pkg::ST_OK;
						done = 1'b1;
					end else if (hit) begin
						status_d = ow_pkg::ST_NOT_GONE;
						done = 1'b1;
					end
				end
				ow_pkg::PH_WR_LOW: begin
					if (hit) begin
						phase_d = ow_pkg::PH_WR_REC;
					end
				end
				ow_pkg::PH_WR_REC: begin
					if (hit) begin
						shift_d = {1'b0, shift_q[7:1]};
						if (count_q == 3'd7) begin
							status_d = ow_pkg::ST_OK;
							done = 1'b1;
						end else begin
							count_d = count_q + 1'b1;
							phase_d = ow_pkg::PH_WR_LOW;
						end
					end
				end
				ow_pkg::PH_RD_LOW: begin
					if (hit) begin
						phase_d = ow_pkg::PH_RD_WAIT;
					end
				end
				ow_pkg::PH_RD_WAIT: begin
					if (hit) begin
						shift_d = {q_item.line_high, shift_q[7:1]};
						phase_d = ow_pkg::PH_RD_TAIL;
					end
				end
				ow_pkg::PH_RD_TAIL: begin
					if (hit) begin
						if (count_q == 3'd7) begin
							rbyte_d = shift_q;
							status_d = ow_pkg::ST_OK;
							done = 1'b1;
						end else begin
							count_d = count_q + 1'b1;
							phase_d = ow_pkg::PH_RD_LOW;
						end
					end
				end
				default: begin
					phase_d = ow_pkg::PH_IDLE;
					timer_d = timer_q;
				end
			endcase
			if (done) begin
				count_d = 3'd0;
				phase_d = ow_pkg::PH_IDLE;
				timer_d = '0;
			end
		end
	end

	// Result item as seen after the item has been applied.
	always_comb begin
		out_d.drive_low = (phase_d inside {ow_pkg::PH_RST_LOW, ow_pkg::PH_WR_LOW,
			ow_pkg::PH_RD_LOW});
		out_d.busy_res = (phase_d != ow_pkg::PH_IDLE);
		out_d.done_res = done;
		out_d.status = status_d;
		out_d.read_data = rbyte_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ow_pkg::PH_IDLE;
			timer_q <= '0;
			shift_q <= '0;
			count_q <= '0;
			status_q <= ow_pkg::ST_OK;
			rbyte_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				timer_q <= timer_d;
				shift_q <= shift_d;
				count_q <= count_d;
				status_q <= status_d;
				rbyte_q <= rbyte_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= out_d;
		end
	end
endmodule

// File: design/ow_checker.sv
// Port-level checks of the one-wire bus master, bound to the top level.
// Depends on ow_pkg and ow_chan_if.
module ow_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input ow_pkg::out_item_t out_data
);
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Stalled result item changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("Finished command still reported busy.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drive_low |-> out_data.busy_res)
		else $error("Bus driven low while idle.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res && out_data.status != ow_pkg::ST_OK
		|-> !out_data.drive_low)
		else $error("Bus driven low after a failed reset.");
endmodule

bind onewire_bus_master ow_checker u_ow_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data(out_ch.data)
);

// File: verif/tb_top.sv
// Self-checking testbench for the one-wire bus master, with random stalls on both channels.
// It holds its own cycle model of the sequencer and compares every result item against it.
// Depends on ow_pkg, ow_chan_if and onewire_bus_master from the design folder.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned HOLD_OFF_CYCLES = 60;

	typedef enum int unsigned {
		SLAVE_GOOD,
		SLAVE_STUCK_LOW,
		SLAVE_ABSENT,
		SLAVE_HOLDS_LOW,
		SLAVE_NOISE
	} slave_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	ow_chan_if #(.T(ow_pkg::in_item_t)) bus_in_if ();
	ow_chan_if #(.T(ow_pkg::out_item_t)) bus_out_if ();
	ow_chan_if #(.T(ow_pkg::cfg_item_t)) cfg_if ();

	onewire_bus_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(bus_in_if),
		.out_ch(bus_out_if),
		.cfg_ch(cfg_if)
	);

	always #4 clk = ~clk;

	ow_pkg::phase_t bm_phase = ow_pkg::PH_IDLE;
	logic [ow_pkg::TIMER_W-1:0] bm_timer = '0;
	logic [7:0] bm_shift = '0;
	logic [2:0] bm_bit_idx = '0;
	logic [1:0] bm_status = ow_pkg::ST_OK;
	logic [7:0] bm_read_byte = '0;
	ow_pkg::cfg_regs_t bm_timing = '{ow_pkg::IDLE_WAIT_RST, ow_pkg::RESET_LOW_RST,
		ow_pkg::PRES_SAMPLE_RST, ow_pkg::RELEASE_WAIT_RST, ow_pkg::ZERO_LOW_RST,
		ow_pkg::ONE_RELEASE_RST, ow_pkg::READ_SAMPLE_RST, ow_pkg::READ_TAIL_RST};

	ow_pkg::out_item_t pending_bus_results[$];
	ow_pkg::out_item_t want_res;
	logic [ow_pkg::CFG_DATA_W-1:0] next_timing [8];
	slave_mode_t slave_mode = SLAVE_NOISE;
	bit no_idling = 1'b0;
	bit hold_off_req = 1'b0;
	int unsigned rx_stall;
	int unsigned idle_cycles = 0;
	int unsigned n_fail = 0;
	int unsigned n_bus_items = 0;
	int unsigned n_started [4] = '{0, 0, 0, 0};
	int unsigned n_status [4] = '{0, 0, 0, 0};

	function automatic void enter_phase(input ow_pkg::phase_t p);
		bm_phase = p;
		bm_timer = '0;
	endfunction

	function automatic bit slot_elapsed(input logic [ow_pkg::TIMER_W-1:0] limit);
		bm_timer = bm_timer + 1'b1;
		if (bm_timer >= limit) begin
			bm_timer = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic ow_pkg::out_item_t predict_master_step(input ow_pkg::in_item_t it);
		ow_pkg::out_item_t res;
		logic done;
		logic cur_bit;
		done = 1'b0;
		cur_bit = bm_shift[0];
		if (bm_phase == ow_pkg::PH_IDLE) begin
			if (it.command != ow_pkg::CMD_NONE) begin
				n_started[it.command]++;
				bm_bit_idx = '0;
				if (it.command == ow_pkg::CMD_RESET) begin
					enter_phase(ow_pkg::PH_RST_IDLE);
				end else if (it.command == ow_pkg::CMD_WRITE) begin
					bm_shift = it.write_data;
					enter_phase(ow_pkg::PH_WR_LOW);
				end else begin
					bm_shift = '0;
					enter_phase(ow_pkg::PH_RD_LOW);
				end
			end
		end else if (it.tick) begin
			case (bm_phase)
				ow_pkg::PH_RST_IDLE: begin
					if (it.line_high) begin
						enter_phase(ow_pkg::PH_RST_LOW);
					end else if (slot_elapsed(
							ow_pkg::TIMER_W'(bm_timing.idle_wait_limit))) begin
						bm_status = ow_pkg::ST_NOT_IDLE;
						done = 1'b1;
					end
				end
				ow_pkg::PH_RST_LOW: begin
					if (slot_elapsed(bm_timing.reset_low_time))
						enter_phase(ow_pkg::PH_RST_PRES);
				end
				ow_pkg::PH_RST_PRES: begin
					if (slot_elapsed(ow_pkg::TIMER_W'(bm_timing.presence_sample_time))) begin
						if (it.line_high) begin
							bm_status = ow_pkg::ST_NOT_PRESENT;
							done = 1'b1;
						end else begin
							enter_phase(ow_pkg::PH_RST_GONE);
						end
					end
				end
				ow_pkg::PH_RST_GONE: begin
					if (it.line_high) begin
						bm_status = ow_pkg::ST_OK;
						done = 1'b1;
					end else if (slot_elapsed(
							ow_pkg::TIMER_W'(bm_timing.release_wait_limit))) begin
						bm_status = ow_pkg::ST_NOT_GONE;
						done = 1'b1;
					end
				end
				ow_pkg::PH_WR_LOW: begin
					if (slot_elapsed(cur_bit ? 10'd1 : 10'(bm_timing.zero_low_time)))
						enter_phase(ow_pkg::PH_WR_REC);
				end
				ow_pkg::PH_WR_REC: begin
					if (slot_elapsed(cur_bit ? 10'(bm_timing.one_release_time) : 10'd1)) begin
						bm_shift = bm_shift >> 1;
						if (bm_bit_idx == 3'd7) begin
							bm_status = ow_pkg::ST_OK;
							done = 1'b1;
						end else begin
							bm_bit_idx = bm_bit_idx + 1'b1;
							enter_phase(ow_pkg::PH_WR_LOW);
						end
					end
				end
				ow_pkg::PH_RD_LOW: begin
					if (slot_elapsed(10'd1))
						enter_phase(ow_pkg::PH_RD_WAIT);
				end
				ow_pkg::PH_RD_WAIT: begin
					if (slot_elapsed(ow_pkg::TIMER_W'(bm_timing.read_sample_time))) begin
						bm_shift = {it.line_high, bm_shift[7:1]};
						enter_phase(ow_pkg::PH_RD_TAIL);
					end
				end
				default: begin
					if (slot_elapsed(ow_pkg::TIMER_W'(bm_timing.read_tail_time))) begin
						if (bm_bit_idx == 3'd7) begin
							bm_read_byte = bm_shift;
							bm_status = ow_pkg::ST_OK;
							done = 1'b1;
						end else begin
							bm_bit_idx = bm_bit_idx + 1'b1;
							enter_phase(ow_pkg::PH_RD_LOW);
						end
					end
				end
			endcase
			if (done) begin
				n_status[bm_status]++;
				bm_bit_idx = '0;
				enter_phase(ow_pkg::PH_IDLE);
			end
		end
		res.drive_low = (bm_phase == ow_pkg::PH_RST_LOW) || (bm_phase == ow_pkg::PH_WR_LOW) ||
			(bm_phase == ow_pkg::PH_RD_LOW);
		res.busy_res = (bm_phase != ow_pkg::PH_IDLE);
		res.done_res = done;
		res.status = bm_status;
		res.read_data = bm_read_byte;
		return res;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(999);
		if (no_idling || r < 750)
			return 0;
		if (r < 985)
			return $urandom_range(3, 1);
		return $urandom_range(30, 12);
	endfunction

	function automatic logic slave_line();
		logic noise;
		noise = 1'($urandom_range(1));
		if (bm_phase inside {ow_pkg::PH_RST_IDLE, ow_pkg::PH_RST_LOW, ow_pkg::PH_RST_PRES,
				ow_pkg::PH_RST_GONE}) begin
			case (slave_mode)
				SLAVE_GOOD: begin
					case (bm_phase)
						ow_pkg::PH_RST_IDLE: return $urandom_range(3) != 0;
						ow_pkg::PH_RST_PRES: return $urandom_range(9) == 0;
						ow_pkg::PH_RST_GONE: return $urandom_range(2) == 0;
						default: return noise;
					endcase
				end
				SLAVE_STUCK_LOW: return 1'b0;
				SLAVE_ABSENT: return 1'b1;
				SLAVE_HOLDS_LOW: return bm_phase == ow_pkg::PH_RST_IDLE;
				default: return noise;
			endcase
		end
		return noise;
	endfunction

	function automatic ow_pkg::in_item_t bus_item(input logic tick, input logic line_high,
			input logic [1:0] command, input logic [7:0] write_data);
		ow_pkg::in_item_t it;
		it.tick = tick;
		it.line_high = line_high;
		it.command = command;
		it.write_data = write_data;
		return it;
	endfunction

	function automatic ow_pkg::in_item_t make_bus_item(input int unsigned tick_pct);
		ow_pkg::in_item_t it;
		it.tick = $urandom_range(99) < tick_pct;
		it.line_high = slave_line();
		it.write_data = 8'($urandom);
		if (bm_phase == ow_pkg::PH_IDLE) begin
			if ($urandom_range(9) < 6) begin
				it.command = 2'($urandom_range(3, 1));
				if (it.command == ow_pkg::CMD_RESET)
					slave_mode = ($urandom_range(7) < 4) ? SLAVE_GOOD :
						slave_mode_t'($urandom_range(4, 1));
			end else begin
				it.command = ow_pkg::CMD_NONE;
			end
		end else begin
			it.command = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : ow_pkg::CMD_NONE;
		end
		return it;
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			n_fail++;
		end
	endfunction

	task automatic send_bus_item(input ow_pkg::in_item_t it);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			bus_in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		bus_in_if.valid <= 1'b1;
		bus_in_if.data <= it;
		@(posedge clk);
		while (!bus_in_if.ready) @(posedge clk);
		pending_bus_results.push_back(predict_master_step(it));
		n_bus_items++;
	endtask

	task automatic run_bus_until_idle(input int unsigned tick_pct);
		while (bm_phase != ow_pkg::PH_IDLE)
			send_bus_item(make_bus_item(tick_pct));
	endtask

	task automatic settle_block();
		@(negedge clk);
		bus_in_if.valid <= 1'b0;
		while (pending_bus_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timing_reg(input ow_pkg::reg_idx_t idx,
			input logic [ow_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= ow_pkg::cfg_item_t'{index: idx, value: value};
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		case (idx)
			ow_pkg::REG_IDLE_WAIT: bm_timing.idle_wait_limit = value[6:0];
			ow_pkg::REG_RESET_LOW: bm_timing.reset_low_time = value[9:0];
			ow_pkg::REG_PRES_SAMPLE: bm_timing.presence_sample_time = value[7:0];
			ow_pkg::REG_RELEASE_WAIT: bm_timing.release_wait_limit = value[7:0];
			ow_pkg::REG_ZERO_LOW: bm_timing.zero_low_time = value[6:0];
			ow_pkg::REG_ONE_RELEASE: bm_timing.one_release_time = value[6:0];
			ow_pkg::REG_READ_SAMPLE: bm_timing.read_sample_time = value[5:0];
			default: bm_timing.read_tail_time = value[6:0];
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic load_timing();
		for (int i = 0; i < 8; i++)
			write_timing_reg(ow_pkg::reg_idx_t'(i), next_timing[i]);
	endtask

	// The default idle wait limit is seen through a reset on a line that never goes high.
	task automatic test_power_on_timing();
		slave_mode = SLAVE_STUCK_LOW;
		send_bus_item(bus_item(1'b1, 1'b0, ow_pkg::CMD_RESET, 8'h00));
		run_bus_until_idle(80);
	endtask

	// Every timing register cleared, so that each step ends on its first tick.
	task automatic test_directed_cases();
		settle_block();
		foreach (next_timing[i])
			next_timing[i] = '0;
		load_timing();
		send_bus_item(bus_item(1'b0, 1'b0, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b1, ow_pkg::CMD_NONE, 8'hFF));
		send_bus_item(bus_item(1'b0, 1'b1, ow_pkg::CMD_RESET, 8'hFF));
		send_bus_item(bus_item(1'b0, 1'b0, ow_pkg::CMD_WRITE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b1, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b0, ow_pkg::CMD_READ, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b0, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b1, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b0, 1'b0, ow_pkg::CMD_RESET, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b0, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b0, ow_pkg::CMD_RESET, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b1, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b1, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b1, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b0, 1'b1, ow_pkg::CMD_RESET, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b1, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b0, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b0, ow_pkg::CMD_NONE, 8'h00));
		send_bus_item(bus_item(1'b1, 1'b0, ow_pkg::CMD_NONE, 8'h00));
		slave_mode = SLAVE_NOISE;
		send_bus_item(bus_item(1'b1, 1'b0, ow_pkg::CMD_WRITE, 8'hFF));
		run_bus_until_idle(100);
		send_bus_item(bus_item(1'b0, 1'b1, ow_pkg::CMD_READ, 8'h5A));
		run_bus_until_idle(100);
	endtask

	// All registers written with all ones, so every value is cut to its own width.
	task automatic test_longest_timing();
		settle_block();
		foreach (next_timing[i])
			next_timing[i] = '1;
		load_timing();
		slave_mode = SLAVE_STUCK_LOW;
		send_bus_item(bus_item(1'b0, 1'b0, ow_pkg::CMD_RESET, 8'hC3));
		run_bus_until_idle(85);
	endtask

	task automatic test_random_traffic();
		int unsigned tick_pct;
		for (int p = 0; p < 6; p++) begin
			settle_block();
			foreach (next_timing[i])
				next_timing[i] = ow_pkg::CFG_DATA_W'($urandom_range((p == 5) ? 12 : 3));
			load_timing();
			no_idling = (p == 2);
			case (p % 3)
				0: tick_pct = 100;
				1: tick_pct = 60;
				default: tick_pct = 25;
			endcase
			repeat (90) send_bus_item(make_bus_item(tick_pct));
			run_bus_until_idle(tick_pct);
		end
		no_idling = 1'b0;
	endtask

	task automatic test_output_backpressure();
		hold_off_req = 1'b1;
		no_idling = 1'b1;
		repeat (40) send_bus_item(make_bus_item(100));
		no_idling = 1'b0;
		run_bus_until_idle(100);
	endtask

	initial begin
		bus_out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				bus_out_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else begin
				rx_stall = pick_gap();
				bus_out_if.ready <= (rx_stall == 0);
				if (rx_stall > 1)
					repeat (rx_stall - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (bus_out_if.valid && bus_out_if.ready) begin
			if (pending_bus_results.size() == 0) begin
				$error("result item arrived with nothing expected");
				n_fail++;
			end else begin
				want_res = pending_bus_results.pop_front();
				compare_field("drive_low", 8'(want_res.drive_low), 8'(bus_out_if.data.drive_low));
				compare_field("busy_res", 8'(want_res.busy_res), 8'(bus_out_if.data.busy_res));
				compare_field("done_res", 8'(want_res.done_res), 8'(bus_out_if.data.done_res));
				compare_field("status", 8'(want_res.status), 8'(bus_out_if.data.status));
				compare_field("read_data", want_res.read_data, bus_out_if.data.read_data);
			end
		end
	end

	always @(posedge clk) begin
		if ((bus_in_if.valid && bus_in_if.ready) || (bus_out_if.valid && bus_out_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Timed out after %0d cycles without an accepted item.", STALL_LIMIT);
			$display("[onewire_bus_master] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		bus_in_if.valid = 1'b0;
		bus_in_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_power_on_timing();
		test_directed_cases();
		test_longest_timing();
		test_random_traffic();
		test_output_backpressure();
		settle_block();
		repeat (6) @(posedge clk);
		$display("Covered %0d items: %0d resets, %0d writes and %0d reads started.",
			n_bus_items, n_started[ow_pkg::CMD_RESET], n_started[ow_pkg::CMD_WRITE],
			n_started[ow_pkg::CMD_READ]);
		$display("Finished with ok %0d, not idle %0d, no presence %0d, not released %0d.",
			n_status[ow_pkg::ST_OK], n_status[ow_pkg::ST_NOT_IDLE],
			n_status[ow_pkg::ST_NOT_PRESENT], n_status[ow_pkg::ST_NOT_GONE]);
		if (n_fail == 0)
			$display("[onewire_bus_master] OK");
		else
			$display("[onewire_bus_master] ERROR");
		$finish;
	end
endmodule

// File: files.f
design/ow_pkg.sv
design/ow_chan_if.sv
design/ow_cfg.sv
design/ow_front.sv
design/ow_back.sv
design/onewire_bus_master.sv
design/ow_checker.sv
verif/tb_top.sv
